@@ src/lden_pkg.sv @@
// Package for the lossy delay network emulator: payload types, opcodes, constants.
// No dependencies.
package lden_pkg;

	localparam logic [63:0] GOLDEN_STEP = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] MIX_MUL_A   = 64'hBF58476D1CE4E5B9;
	localparam logic [63:0] MIX_MUL_B   = 64'h94D049BB133111EB;

	typedef enum logic [1:0] {
		OP_SUBMIT  = 2'd0,
		OP_COLLECT = 2'd1,
		OP_ADVANCE = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_LOSS    = 2'd0,
		REG_LATENCY = 2'd1,
		REG_JITTER  = 2'd2,
		REG_SEED    = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] src_address;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [31:0] payload_tag;
		logic [15:0] payload_length;
		logic [15:0] buffer_size;
		logic [31:0] advance_ticks;
	} in_item_t;

	typedef struct packed {
		logic        found;
		logic [31:0] from_address;
		logic [15:0] from_port;
		logic [31:0] delivered_tag;
		logic [15:0] delivered_length;
		logic [31:0] sent_count;
		logic [31:0] dropped_count;
		logic [31:0] reordered_count;
		logic        table_full;
	} out_item_t;

	typedef struct packed {
		logic [1:0]  index;
		logic [63:0] data;
	} cfg_item_t;

	// Multiplier request/response between sequencer and shared multiplier
	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
	} mul_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] lo;
		logic [63:0] hi;
	} mul_rsp_t;

endpackage

@@ src/lden_if.sv @@
// Valid/ready channel interfaces for items and configuration writes.
// Depends on lden_pkg.
interface lden_in_if import lden_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface lden_out_if import lden_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface lden_cfg_if import lden_pkg::*; ();
	logic      valid;
	logic      ready;
	cfg_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ src/lden_mul.sv @@
// Shared 64x64 multiplier built from one 32x32 partial product per cycle.
// Depends on lden_pkg. Accumulates the partial products into the full 128-bit product.
module lden_mul import lden_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);

	logic [63:0]  a_q, b_q;
	logic [127:0] acc_q;
	logic [2:0]   step_q;
	logic         busy_q;
	logic         done_q;
	logic [31:0]  pa, pb;
	logic [63:0]  pp;
	logic [1:0]   sh_words;
	logic [127:0] pp_sh;

	// Select the partial product for this step
	always_comb begin
		pa = step_q[0] ? a_q[63:32] : a_q[31:0];
		pb = step_q[1] ? b_q[63:32] : b_q[31:0];
		pp = pa * pb;
		sh_words = {1'b0, step_q[0]} + {1'b0, step_q[1]};
		pp_sh = {64'd0, pp} << {sh_words, 5'd0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done_q <= 1'b0;
			a_q <= '0;
			b_q <= '0;
			acc_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
				a_q <= req.a;
				b_q <= req.b;
				acc_q <= '0;
			end else if (busy_q) begin
				acc_q <= acc_q + pp_sh;
				step_q <= step_q + 3'd1;
				if (step_q == 3'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.lo = acc_q[63:0];
	assign rsp.hi = acc_q[127:64];

endmodule

@@ src/lossy_delay_network_emulator.sv @@
// Lossy delay network emulator: one input item in, one result item out.
// Depends on lden_pkg, lden_if and lden_mul.
//
// The block is not ready for a new item while it works on one. A submit draws up to two
// random numbers, each needing two passes through the shared 4-step multiplier, then a
// jitter multiply and a free-slot search of one slot per cycle. A collect scans one slot
// per cycle. The shared multiplier and the one-slot-per-cycle table scan set how long an
// item takes. The result stays in an output register, and the next item is taken once it
// has been delivered. Register writes are taken only while the block is idle.
module lossy_delay_network_emulator import lden_pkg::*; #(
	parameter int WIRE_DEPTH = 32
) (
	input logic        clk,
	input logic        arst_n,
	lden_in_if.sink    in_ch,
	lden_out_if.source out_ch,
	lden_cfg_if.sink   cfg
);

	localparam int IW = (WIRE_DEPTH > 1) ? $clog2(WIRE_DEPTH) : 1;

	typedef enum logic [12:0] {
		ST_IDLE   = 13'b0000000000001,
		ST_DRAW   = 13'b0000000000010,
		ST_MIX1   = 13'b0000000000100,
		ST_MIX2   = 13'b0000000001000,
		ST_LOSS   = 13'b0000000010000,
		ST_JMUL   = 13'b0000000100000,
		ST_FREE   = 13'b0000001000000,
		ST_SCAN   = 13'b0000010000000,
		ST_RD     = 13'b0000100000000,
		ST_PICK   = 13'b0001000000000,
		ST_DONE   = 13'b0010000000000,
		ST_OUT    = 13'b0100000000000,
		ST_LATCH  = 13'b1000000000000
	} state_t;

	state_t state_q;

	// Configuration
	logic [32:0] loss_q;
	logic [31:0] latency_q, jitter_q;
	logic [63:0] gen_q;

	// Counters and time
	logic [31:0] now_q, next_order_q, del_order_q, sent_q, drop_q, reord_q;

	// Current item and scratch
	in_item_t    item_q;
	logic [63:0] z_q;
	logic        jdraw_q;
	logic [31:0] arrival_q;
	logic [IW:0] idx_q;
	logic        best_v_q;
	logic [IW-1:0] best_q;
	logic [31:0] best_arr_q, best_ord_q;
	out_item_t   res_q;
	logic        out_v_q;

	// Slot table: valid bits in flops, payload in a memory
	logic [WIRE_DEPTH-1:0] valid_q;
	logic [47:0] m_src [WIRE_DEPTH];
	logic [15:0] m_dport [WIRE_DEPTH];
	logic [31:0] m_tag [WIRE_DEPTH];
	logic [15:0] m_len [WIRE_DEPTH];
	logic [31:0] m_arr [WIRE_DEPTH];
	logic [31:0] m_ord [WIRE_DEPTH];
	logic [47:0] rd_src_q;
	logic [15:0] rd_dport_q, rd_len_q;
	logic [31:0] rd_tag_q, rd_arr_q, rd_ord_q;
	logic        rd_v_q;
	logic [IW-1:0] rd_idx_q;
	logic [IW-1:0] rd_addr;
	logic        wr_en;

	mul_req_t mreq;
	mul_rsp_t mrsp;

	lden_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mreq), .rsp(mrsp));

	assign in_ch.ready  = (state_q == ST_IDLE) && !out_v_q;
	assign cfg.ready    = (state_q == ST_IDLE);
	assign out_ch.valid = out_v_q;
	assign out_ch.data  = res_q;

	// Memory read address: scan index, or the chosen slot at pick time
	assign rd_addr = (state_q == ST_PICK) ? best_q : idx_q[IW-1:0];
	assign wr_en   = (state_q == ST_FREE) && (idx_q < (IW+1)'(WIRE_DEPTH))
		&& !valid_q[idx_q[IW-1:0]];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			m_src[idx_q[IW-1:0]]   <= {item_q.src_address, item_q.src_port};
			m_dport[idx_q[IW-1:0]] <= item_q.dst_port;
			m_tag[idx_q[IW-1:0]]   <= item_q.payload_tag;
			m_len[idx_q[IW-1:0]]   <= item_q.payload_length;
			m_arr[idx_q[IW-1:0]]   <= arrival_q;
			m_ord[idx_q[IW-1:0]]   <= next_order_q;
		end
		rd_src_q   <= m_src[rd_addr];
		rd_dport_q <= m_dport[rd_addr];
		rd_tag_q   <= m_tag[rd_addr];
		rd_len_q   <= m_len[rd_addr];
		rd_arr_q   <= m_arr[rd_addr];
		rd_ord_q   <= m_ord[rd_addr];
	end

	// Multiplier operands by state
	always_comb begin
		mreq.start = 1'b0;
		mreq.a = z_q;
		mreq.b = MIX_MUL_A;
		case (state_q)
			ST_DRAW: begin
				mreq.start = 1'b1;
				mreq.a = (gen_q + GOLDEN_STEP) ^ ((gen_q + GOLDEN_STEP) >> 30);
				mreq.b = MIX_MUL_A;
			end
			ST_MIX1: begin
				mreq.start = mrsp.done;
				mreq.a = mrsp.lo ^ (mrsp.lo >> 27);
				mreq.b = MIX_MUL_B;
			end
			ST_LOSS: begin
				mreq.start = jdraw_q;
				mreq.a = {32'd0, z_q[63:32]};
				mreq.b = {32'd0, jitter_q};
			end
			default: begin
				mreq.start = 1'b0;
			end
		endcase
	end

	logic [63:0] mixed;
	logic        cand;
	assign mixed = mrsp.lo ^ (mrsp.lo >> 31);
	assign cand = rd_v_q && (rd_dport_q == item_q.dst_port) && (rd_arr_q <= now_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			loss_q <= '0;
			latency_q <= '0;
			jitter_q <= '0;
			gen_q <= GOLDEN_STEP;
			now_q <= '0;
			next_order_q <= '0;
			del_order_q <= '0;
			sent_q <= '0;
			drop_q <= '0;
			reord_q <= '0;
			valid_q <= '0;
			out_v_q <= 1'b0;
			idx_q <= '0;
			best_v_q <= 1'b0;
			rd_v_q <= 1'b0;
			jdraw_q <= 1'b0;
		end else begin
			if (out_v_q && out_ch.ready) out_v_q <= 1'b0;
			// Configuration writes
			if (cfg.valid && state_q == ST_IDLE) begin
				case (reg_idx_t'(cfg.data.index))
					REG_LOSS:    loss_q <= cfg.data.data[32:0];
					REG_LATENCY: latency_q <= cfg.data.data[31:0];
					REG_JITTER:  jitter_q <= cfg.data.data[31:0];
					REG_SEED:    gen_q <= (cfg.data.data != 64'd0) ? cfg.data.data : GOLDEN_STEP;
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (in_ch.valid && !out_v_q) begin
						item_q <= in_ch.data;
						res_q <= '0;
						case (op_t'(in_ch.data.operation))
							OP_SUBMIT: begin
								sent_q <= sent_q + 32'd1;
								arrival_q <= now_q + latency_q;
								jdraw_q <= 1'b0;
								if (loss_q != 33'd0) state_q <= ST_DRAW;
								else if (jitter_q != 32'd0) begin
									jdraw_q <= 1'b1;
									state_q <= ST_DRAW;
								end else begin
									idx_q <= '0;
									state_q <= ST_FREE;
								end
							end
							OP_COLLECT: begin
								idx_q <= '0;
								best_v_q <= 1'b0;
								rd_v_q <= 1'b0;
								state_q <= ST_SCAN;
							end
							OP_ADVANCE: begin
								now_q <= now_q + in_ch.data.advance_ticks;
								state_q <= ST_DONE;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				// One splitmix64 draw
				ST_DRAW: begin
					gen_q <= gen_q + GOLDEN_STEP;
					state_q <= ST_MIX1;
				end
				ST_MIX1: if (mrsp.done) state_q <= ST_MIX2;
				ST_MIX2: if (mrsp.done) begin
					z_q <= mixed;
					state_q <= ST_LOSS;
				end
				// Loss decision or jitter launch
				ST_LOSS: begin
					if (jdraw_q) state_q <= ST_JMUL;
					else if ({1'b0, z_q[63:32]} < loss_q) begin
						drop_q <= drop_q + 32'd1;
						state_q <= ST_DONE;
					end else if (jitter_q != 32'd0) begin
						jdraw_q <= 1'b1;
						state_q <= ST_DRAW;
					end else begin
						idx_q <= '0;
						state_q <= ST_FREE;
					end
				end
				ST_JMUL: if (mrsp.done) begin
					arrival_q <= arrival_q + mrsp.lo[63:32];
					idx_q <= '0;
					state_q <= ST_FREE;
				end
				// Free-slot search, one slot a cycle
				ST_FREE: begin
					if (idx_q == (IW+1)'(WIRE_DEPTH)) begin
						res_q.table_full <= 1'b1;
						state_q <= ST_DONE;
					end else if (!valid_q[idx_q[IW-1:0]]) begin
						valid_q[idx_q[IW-1:0]] <= 1'b1;
						next_order_q <= next_order_q + 32'd1;
						state_q <= ST_DONE;
					end else idx_q <= idx_q + 1'b1;
				end
				// Collect scan: read slot idx, compare the previous read
				ST_SCAN: begin
					if (cand && (!best_v_q || rd_arr_q < best_arr_q
						|| (rd_arr_q == best_arr_q && rd_ord_q < best_ord_q))) begin
						best_v_q <= 1'b1;
						best_q <= rd_idx_q;
						best_arr_q <= rd_arr_q;
						best_ord_q <= rd_ord_q;
					end
					if (idx_q == (IW+1)'(WIRE_DEPTH)) begin
						rd_v_q <= 1'b0;
						state_q <= ST_RD;
					end else begin
						rd_v_q <= valid_q[idx_q[IW-1:0]];
						rd_idx_q <= idx_q[IW-1:0];
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_RD: state_q <= best_v_q ? ST_PICK : ST_DONE;
				ST_PICK: state_q <= ST_LATCH;
				ST_LATCH: begin
					valid_q[best_q] <= 1'b0;
					if (best_ord_q < del_order_q) reord_q <= reord_q + 32'd1;
					else del_order_q <= best_ord_q;
					res_q.found <= 1'b1;
					res_q.from_address <= rd_src_q[47:16];
					res_q.from_port <= rd_src_q[15:0];
					res_q.delivered_tag <= rd_tag_q;
					res_q.delivered_length <= (rd_len_q < item_q.buffer_size)
						? rd_len_q : item_q.buffer_size;
					state_q <= ST_DONE;
				end
				ST_DONE: state_q <= ST_OUT;
				ST_OUT: begin
					res_q.sent_count <= sent_q;
					res_q.dropped_count <= drop_q;
					res_q.reordered_count <= reord_q;
					out_v_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ tb/lden_checker.sv @@
// Checker for the lossy delay network emulator: tracks config writes and accepted items,
// predicts each result and compares it with what the block delivers.
// Depends on lden_pkg and the channel interfaces in lden_if.
module lden_checker import lden_pkg::*; #(
	parameter int WIRE_DEPTH = 32
) (
	input logic         clk,
	input logic         arst_n,
	lden_in_if          in_ch,
	lden_out_if         out_ch,
	lden_cfg_if         cfg,
	output int unsigned errors,
	output int unsigned outstanding
);

	// Shadow configuration
	logic [32:0] loss_thr;
	logic [31:0] latency;
	logic [31:0] jitter;

	// Shadow link state
	logic [63:0] rng;
	logic [31:0] now_ticks;
	logic [31:0] order_next;
	logic [31:0] order_last;
	logic [31:0] n_sent;
	logic [31:0] n_lost;
	logic [31:0] n_reorder;
	logic        wire_busy [WIRE_DEPTH];
	logic [31:0] wire_addr [WIRE_DEPTH];
	logic [15:0] wire_sport [WIRE_DEPTH];
	logic [15:0] wire_dport [WIRE_DEPTH];
	logic [31:0] wire_tag [WIRE_DEPTH];
	logic [15:0] wire_len [WIRE_DEPTH];
	logic [31:0] wire_due [WIRE_DEPTH];
	logic [31:0] wire_ord [WIRE_DEPTH];

	out_item_t expected_results [$];

	// splitmix64 step, returns the upper 32 bits of the mix
	function automatic logic [31:0] next_fraction();
		logic [63:0] z;
		rng = rng + GOLDEN_STEP;
		z = rng;
		z = (z ^ (z >> 30)) * MIX_MUL_A;
		z = (z ^ (z >> 27)) * MIX_MUL_B;
		z = z ^ (z >> 31);
		return z[63:32];
	endfunction

	// Apply one item to the shadow link and return the result it must produce
	function automatic out_item_t emulate_link(in_item_t it);
		out_item_t   r;
		logic [31:0] due;
		logic [63:0] prod;
		int          slot;
		int          pick;
		r = '0;
		slot = -1;
		pick = -1;
		case (op_t'(it.operation))
			OP_SUBMIT: begin
				n_sent = n_sent + 32'd1;
				if (loss_thr != 33'd0 && {1'b0, next_fraction()} < loss_thr) begin
					n_lost = n_lost + 32'd1;
				end else begin
					due = now_ticks + latency;
					if (jitter != 32'd0) begin
						prod = {32'd0, next_fraction()} * {32'd0, jitter};
						due = due + prod[63:32];
					end
					for (int i = 0; i < WIRE_DEPTH; i++)
						if (slot < 0 && !wire_busy[i]) slot = i;
					if (slot < 0) begin
						r.table_full = 1'b1;
					end else begin
						wire_busy[slot] = 1'b1;
						wire_addr[slot] = it.src_address;
						wire_sport[slot] = it.src_port;
						wire_dport[slot] = it.dst_port;
						wire_tag[slot] = it.payload_tag;
						wire_len[slot] = it.payload_length;
						wire_due[slot] = due;
						wire_ord[slot] = order_next;
						order_next = order_next + 32'd1;
					end
				end
			end
			OP_COLLECT: begin
				for (int i = 0; i < WIRE_DEPTH; i++) begin
					if (wire_busy[i] && wire_dport[i] == it.dst_port && wire_due[i] <= now_ticks)
						if (pick < 0 || wire_due[i] < wire_due[pick] ||
						    (wire_due[i] == wire_due[pick] && wire_ord[i] < wire_ord[pick]))
							pick = i;
				end
				if (pick >= 0) begin
					wire_busy[pick] = 1'b0;
					if (wire_ord[pick] < order_last) n_reorder = n_reorder + 32'd1;
					else order_last = wire_ord[pick];
					r.found = 1'b1;
					r.from_address = wire_addr[pick];
					r.from_port = wire_sport[pick];
					r.delivered_tag = wire_tag[pick];
					r.delivered_length = (wire_len[pick] < it.buffer_size) ?
						wire_len[pick] : it.buffer_size;
				end
			end
			OP_ADVANCE: now_ticks = now_ticks + it.advance_ticks;
			default: ;
		endcase
		r.sent_count = n_sent;
		r.dropped_count = n_lost;
		r.reordered_count = n_reorder;
		return r;
	endfunction

	function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] got_v,
			ref bit bad);
		if (exp_v !== got_v) begin
			bad = 1'b1;
			if (errors < 10)
				$display("mismatch %s: expected %0h, got %0h", name, exp_v, got_v);
		end
	endfunction

	// Observe config writes, accepted items and delivered results
	always @(posedge clk or negedge arst_n) begin
		out_item_t e;
		out_item_t g;
		bit        bad;
		if (!arst_n) begin
			loss_thr = '0;
			latency = '0;
			jitter = '0;
			rng = GOLDEN_STEP;
			now_ticks = '0;
			order_next = '0;
			order_last = '0;
			n_sent = '0;
			n_lost = '0;
			n_reorder = '0;
			for (int i = 0; i < WIRE_DEPTH; i++) wire_busy[i] = 1'b0;
			expected_results.delete();
			errors <= 0;
			outstanding <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (reg_idx_t'(cfg.data.index))
					REG_LOSS:    loss_thr = cfg.data.data[32:0];
					REG_LATENCY: latency = cfg.data.data[31:0];
					REG_JITTER:  jitter = cfg.data.data[31:0];
					REG_SEED:    rng = (cfg.data.data != 64'd0) ? cfg.data.data : GOLDEN_STEP;
					default: ;
				endcase
			end
			if (in_ch.valid && in_ch.ready)
				expected_results = {expected_results, emulate_link(in_ch.data)};
			if (out_ch.valid && out_ch.ready) begin
				g = out_ch.data;
				if (expected_results.size() == 0) begin
					if (errors < 10) $display("unexpected result: %p", g);
					errors <= errors + 1;
				end else begin
					e = expected_results.pop_front();
					bad = 1'b0;
					check_field("found", 64'(e.found), 64'(g.found), bad);
					check_field("from_address", 64'(e.from_address), 64'(g.from_address), bad);
					check_field("from_port", 64'(e.from_port), 64'(g.from_port), bad);
					check_field("delivered_tag", 64'(e.delivered_tag), 64'(g.delivered_tag),
						bad);
					check_field("delivered_length", 64'(e.delivered_length),
						64'(g.delivered_length), bad);
					check_field("sent_count", 64'(e.sent_count), 64'(g.sent_count), bad);
					check_field("dropped_count", 64'(e.dropped_count), 64'(g.dropped_count),
						bad);
					check_field("reordered_count", 64'(e.reordered_count),
						64'(g.reordered_count), bad);
					check_field("table_full", 64'(e.table_full), 64'(g.table_full), bad);
					if (bad) errors <= errors + 1;
				end
			end
			outstanding <= expected_results.size();
		end
	end

endmodule

@@ tb/lossy_delay_network_emulator_tb.sv @@
// Testbench top for the lossy delay network emulator: clock, reset, config phases,
// directed and random items, receiver stalls and the verdict.
// Depends on lden_pkg, lden_if, lden_checker and the block itself.
module lossy_delay_network_emulator_tb;
	import lden_pkg::*;

	localparam int  WIRE_DEPTH = 32;
	localparam int  CYCLE_LIMIT = 3_000_000;
	localparam int  DRAIN_CYCLES = 120;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	int unsigned errors;
	int unsigned outstanding;
	int          send_idle = 0;
	int          recv_idle = 0;
	bit          hold_req = 1'b0;
	bit          hold_done = 1'b0;
	int          hold_left = 0;
	int unsigned cycles = 0;

	lden_in_if  in_ch ();
	lden_out_if out_ch ();
	lden_cfg_if cfg ();

	lossy_delay_network_emulator #(.WIRE_DEPTH(WIRE_DEPTH)) dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
	);

	lden_checker #(.WIRE_DEPTH(WIRE_DEPTH)) link_checker (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg),
		.errors(errors), .outstanding(outstanding)
	);

	always #5 clk = ~clk;

	// Receiver: random stalls, plus one long hold-off when asked
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ch.ready <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_left <= 400;
			hold_done <= 1'b1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic send_item(in_item_t it);
		while ($urandom_range(99) < send_idle) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= it;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	function automatic in_item_t make_item(op_t op, logic [15:0] port);
		in_item_t it;
		it.operation = op;
		it.src_address = $urandom;
		it.src_port = 16'($urandom);
		it.dst_port = port;
		it.payload_tag = $urandom;
		it.payload_length = ($urandom_range(1)) ? 16'($urandom) : 16'($urandom_range(1500));
		it.buffer_size = ($urandom_range(1)) ? 16'($urandom) : 16'($urandom_range(1500));
		it.advance_ticks = $urandom_range(20);
		return it;
	endfunction

	function automatic in_item_t random_item(int submit_pct);
		in_item_t    it;
		int          pick;
		logic [15:0] port;
		pick = $urandom_range(99);
		port = ($urandom_range(3) != 0) ? 16'($urandom_range(3)) : 16'($urandom);
		if (pick < submit_pct) it = make_item(OP_SUBMIT, port);
		else if (pick < 85) it = make_item(OP_COLLECT, port);
		else if (pick < 97) it = make_item(OP_ADVANCE, port);
		else it = make_item(OP_NONE, port);
		case ($urandom_range(19))
			0: it.advance_ticks = $urandom;
			1: it.advance_ticks = 32'hFFFF_FFFF;
			default: ;
		endcase
		return it;
	endfunction

	// Let the block settle before touching its registers
	task automatic quiesce();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(reg_idx_t idx, logic [63:0] val);
		cfg.valid <= 1'b1;
		cfg.data <= '{index: idx, data: val};
		do @(posedge clk); while (!cfg.ready);
	endtask

	task automatic configure(logic [32:0] loss, logic [31:0] lat, logic [31:0] jit,
			logic [63:0] seed);
		put_reg(REG_LOSS, {31'd0, loss});
		put_reg(REG_LATENCY, {32'd0, lat});
		put_reg(REG_JITTER, {32'd0, jit});
		put_reg(REG_SEED, seed);
		cfg.valid <= 1'b0;
	endtask

	task automatic random_phase(int n_items);
		int burst;
		for (int k = 0; k < n_items; k++) begin
			// now and then a burst of submits to overflow the table
			if ($urandom_range(60) == 0) begin
				burst = WIRE_DEPTH + 4;
				repeat (burst) send_item(make_item(OP_SUBMIT, 16'($urandom_range(3))));
				k += burst;
			end else begin
				send_item(random_item(45));
			end
		end
	endtask

	initial begin
		in_item_t it;
		in_ch.valid <= 1'b0;
		in_ch.data <= '0;
		cfg.valid <= 1'b0;
		cfg.data <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: defaults, field extremes, every operation
		configure(33'd0, 32'd0, 32'd0, 64'd0);
		it = '1;
		it.operation = OP_SUBMIT;
		send_item(it);
		it = '0;
		send_item(it);
		it = make_item(OP_ADVANCE, 16'd0);
		it.advance_ticks = 32'd0;
		send_item(it);
		it = '1;
		it.operation = OP_COLLECT;
		it.buffer_size = 16'd0;
		send_item(it);
		it = '0;
		it.operation = OP_COLLECT;
		it.buffer_size = 16'hFFFF;
		send_item(it);
		it = '1;
		it.operation = OP_NONE;
		send_item(it);
		// same arrival for three datagrams: order decides
		repeat (3) send_item(make_item(OP_SUBMIT, 16'd5));
		repeat (4) send_item(make_item(OP_COLLECT, 16'd5));
		// time wrap
		it = make_item(OP_ADVANCE, 16'd0);
		it.advance_ticks = 32'hFFFF_FFFF;
		send_item(it);
		send_item(it);
		quiesce();

		// Directed: full loss, max jitter, large latency
		configure(33'h1_0000_0000, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		repeat (3) send_item(make_item(OP_SUBMIT, 16'd1));
		quiesce();
		configure(33'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, {$urandom, $urandom});
		repeat (3) send_item(make_item(OP_SUBMIT, 16'd2));
		it = make_item(OP_ADVANCE, 16'd0);
		it.advance_ticks = 32'hFFFF_FFFF;
		send_item(it);
		repeat (3) send_item(make_item(OP_COLLECT, 16'd2));
		quiesce();

		// Random phases
		send_idle = 10;
		recv_idle = 68;
		configure(33'h0_4000_0000, 32'd3, 32'd16, {$urandom, $urandom});
		random_phase(330);
		quiesce();

		send_idle = 68;
		recv_idle = 10;
		configure(33'($urandom), 32'($urandom_range(8)), 32'd0, 64'd0);
		random_phase(330);
		quiesce();

		send_idle = 0;
		recv_idle = 0;
		configure(33'd0, 32'd0, 32'($urandom_range(40)), {$urandom, $urandom});
		hold_req = 1'b1;
		random_phase(340);
		quiesce();

		// Wait out remaining results, with a bound
		while (outstanding != 0 && cycles < CYCLE_LIMIT) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && outstanding == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
